>>> hdl/dmss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmss_pkg: shared types and constants
// Command codes, digit ranks, select patterns and the segment font of the
// dual meter display scanner.
// ----------------------------------------------------------------------------
package dmss_pkg;

    localparam int SAMPLE_W = 10;
    localparam int VALUE_W  = 9;
    localparam int RANK_W   = 3;
    localparam int SEG_W    = 8;
    localparam int SEL_W    = 8;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [RANK_W-1:0] RANK_NONE      = 3'd0;
    localparam logic [RANK_W-1:0] RANK_UNITS     = 3'd1;
    localparam logic [RANK_W-1:0] RANK_TENS      = 3'd2;
    localparam logic [RANK_W-1:0] RANK_HUNDREDS  = 3'd3;
    localparam logic [RANK_W-1:0] RANK_THOUSANDS = 3'd4;

    localparam logic [SEL_W-1:0] SEL_UNITS     = 8'b1111_1110;
    localparam logic [SEL_W-1:0] SEL_TENS      = 8'b1111_1101;
    localparam logic [SEL_W-1:0] SEL_HUNDREDS  = 8'b1111_1011;
    localparam logic [SEL_W-1:0] SEL_THOUSANDS = 8'b1111_0111;

    localparam logic [SEG_W-1:0] SEG_ZERO = 8'h3F;
    localparam logic [SEG_W-1:0] SEG_DOT  = 8'h80;

    typedef struct packed {
        logic                sample_en;
        logic [SAMPLE_W-1:0] sample;
    } t_meter_ctl;

    function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = SEG_ZERO;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

>>> hdl/dual_meter_seven_segment_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_meter_seven_segment_scan: voltmeter and ammeter display scanner
// A beat on the input channel is a converter sample (cmd 0) or a refresh
// tick (cmd 1). Samples alternate voltage, current, voltage, ... and update
// the stored readings; they produce no output beat. Each tick advances the
// scanned digit units, tens, hundreds, thousands and wraps, and produces one
// output beat with the digit select and both segment codes.
// Path: a beat is captured in the input register and processed from there;
// for a tick the output register then holds the result and offers the
// output beat, once any earlier output beat has been taken.
// One beat per cycle is sustained while no tick waits on a full output register.
// Reset clears both readings to zero, expects the voltage channel next and
// makes the first tick show units.
// When the receiver stalls, samples keep flowing through the input register;
// a tick that finds the output register still full waits in the input
// register, and o_in_ready drops until the output beat is taken.
// ----------------------------------------------------------------------------
module dual_meter_seven_segment_scan #(
    parameter int ADC_BITS = 10
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire                            i_cmd,
    input  wire  [dmss_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [dmss_pkg::SEL_W-1:0]     o_rank_select,
    output logic [dmss_pkg::SEG_W-1:0]     o_voltage_segments,
    output logic [dmss_pkg::SEG_W-1:0]     o_current_segments
);
    import dmss_pkg::*;

    logic                r_s1_valid;
    logic                r_s1_cmd;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic [RANK_W-1:0]   r_rank;
    logic                r_out_valid;
    logic [SEL_W-1:0]    r_rank_select;
    logic [SEG_W-1:0]    r_voltage_seg;
    logic [SEG_W-1:0]    r_current_seg;

    logic [RANK_W-1:0]   n_rank;
    logic [SEL_W-1:0]    n_rank_select;
    logic                w_advance;
    logic                w_tick;
    t_meter_ctl          w_ctl;
    logic [VALUE_W-1:0]  w_voltage;
    logic [VALUE_W-1:0]  w_current;
    logic [SEG_W-1:0]    w_voltage_seg;
    logic [SEG_W-1:0]    w_current_seg;

    assign w_advance  = r_s1_valid &&
                        (r_s1_cmd == CMD_SAMPLE || !r_out_valid || i_out_ready);
    assign w_tick     = w_advance && r_s1_cmd == CMD_TICK;
    assign o_in_ready = !r_s1_valid || w_advance;

    assign w_ctl.sample_en = w_advance && r_s1_cmd == CMD_SAMPLE;
    assign w_ctl.sample    = r_s1_sample;

    dmss_meter #(
        .ADC_BITS (ADC_BITS)
    ) u_meter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .o_voltage (w_voltage),
        .o_current (w_current)
    );

    always_comb begin
        n_rank = (r_rank >= RANK_THOUSANDS) ? RANK_UNITS : r_rank + 3'd1;
        case (n_rank)
            RANK_UNITS:    n_rank_select = SEL_UNITS;
            RANK_TENS:     n_rank_select = SEL_TENS;
            RANK_HUNDREDS: n_rank_select = SEL_HUNDREDS;
            default:       n_rank_select = SEL_THOUSANDS;
        endcase
    end

    dmss_digit u_voltage_digit (
        .i_value (w_voltage),
        .i_rank  (n_rank),
        .o_code  (w_voltage_seg)
    );

    dmss_digit u_current_digit (
        .i_value (w_current),
        .i_rank  (n_rank),
        .o_code  (w_current_seg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_cmd    <= i_cmd;
            r_s1_sample <= i_sample;
        end
    end

    // scan rank and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank      <= RANK_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_tick) begin
                r_rank      <= n_rank;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_rank_select <= n_rank_select;
            r_voltage_seg <= w_voltage_seg;
            r_current_seg <= w_current_seg;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_rank_select      = r_rank_select;
    assign o_voltage_segments = r_voltage_seg;
    assign o_current_segments = r_current_seg;

    // checks
    a_rank_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rank <= RANK_THOUSANDS)
        else $error("scan rank out of range");

    a_one_digit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones(o_rank_select) == SEL_W - 1)
        else $error("digit select not one-cold");

    a_dot_hundreds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_voltage_segments[SEG_W-1] == (o_rank_select == SEL_HUNDREDS))
                     && (o_current_segments[SEG_W-1] == (o_rank_select == SEL_HUNDREDS)))
        else $error("decimal point on wrong digit");

    a_thousands_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rank_select == SEL_THOUSANDS |->
            o_voltage_segments == SEG_ZERO && o_current_segments == SEG_ZERO)
        else $error("thousands digit not zero");

endmodule
`default_nettype wire

>>> hdl/dmss_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmss_meter: two-channel reading scaler
// Alternates samples between the voltage and current channels and keeps
// both readings scaled to hundredths with one shared constant multiplier.
// ----------------------------------------------------------------------------
module dmss_meter #(
    parameter int ADC_BITS = 10
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  dmss_pkg::t_meter_ctl          i_ctl,
    output logic [dmss_pkg::VALUE_W-1:0]  o_voltage,
    output logic [dmss_pkg::VALUE_W-1:0]  o_current
);
    import dmss_pkg::*;

    localparam int RAW_W  = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam int PROD_W = RAW_W + 9;
    localparam logic [PROD_W-1:0] FULL_SCALE = PROD_W'(500);

    logic               r_second;
    logic [RAW_W-1:0]   r_first_raw;
    logic [VALUE_W-1:0] r_voltage;
    logic [VALUE_W-1:0] r_current;

    logic [RAW_W-1:0]   w_raw;
    logic [RAW_W-1:0]   w_operand;
    logic               w_negative;
    logic [PROD_W-1:0]  w_prod;
    logic [PROD_W-1:0]  w_shift;
    logic [VALUE_W-1:0] w_scaled;

    assign w_raw      = i_ctl.sample[RAW_W-1:0];
    assign w_negative = w_raw > r_first_raw;
    assign w_operand  = r_second ? (r_first_raw - w_raw) : w_raw;
    assign w_prod     = PROD_W'(w_operand) * FULL_SCALE;
    assign w_shift    = w_prod >> ADC_BITS;
    assign w_scaled   = w_shift[VALUE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second    <= 1'b0;
            r_first_raw <= '0;
            r_voltage   <= '0;
            r_current   <= '0;
        end else if (i_ctl.sample_en) begin
            r_second <= ~r_second;
            if (!r_second) begin
                r_first_raw <= w_raw;
                r_voltage   <= w_scaled;
            end else begin
                r_current <= w_negative ? '0 : w_scaled;
            end
        end
    end

    assign o_voltage = r_voltage;
    assign o_current = r_current;

endmodule
`default_nettype wire

>>> hdl/dmss_digit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmss_digit: decimal digit to segment encoder
// Splits a reading into decimal digits by reciprocal multiplication and
// returns the segment code of the scanned digit, dot on hundreds.
// ----------------------------------------------------------------------------
module dmss_digit (
    input  wire  [dmss_pkg::VALUE_W-1:0] i_value,
    input  wire  [dmss_pkg::RANK_W-1:0]  i_rank,
    output logic [dmss_pkg::SEG_W-1:0]   o_code
);
    import dmss_pkg::*;

    logic [14:0] w_h_prod;
    logic [2:0]  w_hundreds;
    logic [VALUE_W-1:0] w_rem_full;
    logic [6:0]  w_rem;
    logic [14:0] w_t_prod;
    logic [3:0]  w_tens;
    logic [6:0]  w_units_full;
    logic [3:0]  w_digit;

    // floor(v / 100) for v below 512
    assign w_h_prod     = 15'(i_value) * 15'd41;
    assign w_hundreds   = w_h_prod[14:12];
    assign w_rem_full   = i_value - VALUE_W'(w_hundreds) * VALUE_W'(100);
    assign w_rem        = w_rem_full[6:0];
    // floor(r / 10) for r below 100
    assign w_t_prod     = 15'(w_rem) * 15'd205;
    assign w_tens       = w_t_prod[14:11];
    assign w_units_full = w_rem - 7'(w_tens) * 7'd10;

    always_comb begin
        case (i_rank)
            RANK_UNITS:    w_digit = w_units_full[3:0];
            RANK_TENS:     w_digit = w_tens;
            RANK_HUNDREDS: w_digit = {1'b0, w_hundreds};
            default:       w_digit = 4'd0;
        endcase
        o_code = seg_font(w_digit);
        if (i_rank == RANK_HUNDREDS) begin
            o_code = o_code | SEG_DOT;
        end
    end

endmodule
`default_nettype wire
